/* hdl/rds_pkg.sv */
// Shared widths and types for the running delay statistics block.
// No dependencies; used by rds_div, rds_table and the top level.
`default_nettype none
package rds_pkg;
   localparam int TABLE_DEPTH_DEF = 16;
   localparam int DELAY_BITS_DEF  = 16;
   localparam int RTT_W   = 16;
   localparam int KEY_W   = 32;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 48;
   localparam int SQS_W   = 64;
   localparam int MEAN_W  = 24;
   localparam int VAR_W   = 40;
   localparam int FRAC_W  = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 136;

   // Table lookup/update outcome
   typedef struct packed {
      logic             found;
      logic             full;
      logic [CNT_W-1:0] hits;
   } tbl_res_type;
endpackage
`default_nettype wire

/* hdl/rds_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses rds_pkg for the divisor width.
`default_nettype none
module rds_div #(
   parameter int DVD_W = 56
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DVD_W-1:0]         dividend,
   input  wire logic [rds_pkg::CNT_W-1:0] divisor,
   output logic                          busy,
   output logic [DVD_W-1:0]              quotient
);
   import rds_pkg::*;
   localparam int IT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [IT_W-1:0]  it_ff, it_in;
   logic             busy_ff, busy_in;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   diff;

   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      diff   = trial - {1'b0, divisor};
      quo_in = quo_ff;
      rem_in = rem_ff;
      it_in  = it_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         it_in   = IT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         it_in = it_ff - 1'b1;
         if (it_ff == IT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         it_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         it_ff   <= it_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* hdl/rds_table.sv */
// Per-target hit table: keys and counters in memories, scanned one entry a cycle.
// Uses rds_pkg for widths and the result struct.
`default_nettype none
module rds_table #(
   parameter int TABLE_DEPTH = rds_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      insert,
   input  wire logic [rds_pkg::KEY_W-1:0] key,
   output logic                           busy,
   output rds_pkg::tbl_res_type           result
);
   import rds_pkg::*;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCN_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_SCAN = 2'd1;
   localparam logic [1:0] T_UPD  = 2'd2;

   logic [KEY_W-1:0] key_mem  [TABLE_DEPTH];
   logic [CNT_W-1:0] hits_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [1:0]       state_ff;
   logic [SCN_W-1:0] scn_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [CNT_W-1:0] rd_hits_ff;
   logic             rd_vld_ff;
   logic [KEY_W-1:0] key_ff;
   logic             ins_ff;
   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [CNT_W-1:0] hit_cnt_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;
   tbl_res_type      res_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CNT_W-1:0] wr_hits;
   logic             wr_key;
   logic [CNT_W-1:0] hits_inc;

   assign rd_addr  = scn_ff[IDX_W-1:0];
   assign hits_inc = (hit_cnt_ff == '1) ? hit_cnt_ff : hit_cnt_ff + 1'b1;

   always_comb begin
      wr_en   = 1'b0;
      wr_key  = 1'b0;
      wr_addr = hit_idx_ff;
      wr_hits = hits_inc;
      if (state_ff == T_UPD && ins_ff) begin
         if (hit_ff) begin
            wr_en = 1'b1;
         end else if (free_ff) begin
            wr_en   = 1'b1;
            wr_key  = 1'b1;
            wr_addr = free_idx_ff;
            wr_hits = CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[rd_addr];
      rd_hits_ff <= hits_mem[rd_addr];
      if (wr_en) begin
         hits_mem[wr_addr] <= wr_hits;
      end
      if (wr_key) begin
         key_mem[wr_addr] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
         scn_ff   <= '0;
      end else begin
         case (state_ff)
            T_IDLE: begin
               if (start) begin
                  state_ff <= T_SCAN;
                  scn_ff   <= '0;
                  pend_ff  <= 1'b0;
                  key_ff   <= key;
                  ins_ff   <= insert;
                  hit_ff   <= 1'b0;
                  free_ff  <= 1'b0;
               end
            end
            T_SCAN: begin
               if (pend_ff) begin
                  if (rd_vld_ff && rd_key_ff == key_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= rd_idx_ff;
                     hit_cnt_ff <= rd_hits_ff;
                  end
                  if (!rd_vld_ff && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= rd_idx_ff;
                  end
               end
               if (scn_ff != SCN_W'(TABLE_DEPTH)) begin
                  pend_ff   <= 1'b1;
                  rd_idx_ff <= rd_addr;
                  rd_vld_ff <= valid_ff[rd_addr];
                  scn_ff    <= scn_ff + 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  if (!pend_ff) begin
                     state_ff <= T_UPD;
                  end
               end
            end
            T_UPD: begin
               state_ff     <= T_IDLE;
               res_ff.full  <= ins_ff && !hit_ff && !free_ff;
               res_ff.found <= hit_ff || (ins_ff && free_ff);
               if (hit_ff) begin
                  res_ff.hits <= ins_ff ? hits_inc : hit_cnt_ff;
               end else if (ins_ff && free_ff) begin
                  res_ff.hits <= CNT_W'(1);
               end else begin
                  res_ff.hits <= '0;
               end
               if (wr_key) begin
                  valid_ff[wr_addr] <= 1'b1;
               end
            end
            default: state_ff <= T_IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != T_IDLE);
   assign result = res_ff;
endmodule
`default_nettype wire

/* hdl/running_delay_statistics.sv */
// Top level of the running delay statistics block.
// Depends on rds_pkg, rds_div and rds_table.
`default_nettype none
// One item is in work at a time. The two bit-serial dividers for the mean (56-bit
// quotient) and the mean square (72-bit quotient) run side by side, overlapped with
// a one-entry-per-cycle scan of the target table. A finished result waits in the
// output register while the next transaction is accepted.
// tdata fields, lowest bit first:
// request {rtt_ticks, target_address}, tuser = req_type; response
// {sample_total, mean_q8, variance_q8, target_count, target_found,
// table_full, sample_dropped}, zero padded.
module running_delay_statistics #(
   parameter int TABLE_DEPTH = rds_pkg::TABLE_DEPTH_DEF,
   parameter int DELAY_BITS  = rds_pkg::DELAY_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // rtt_ticks[15:0], target_address[47:16]
   input  wire logic [rds_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // sample_total[31:0], mean_q8[55:32], variance_q8[95:56], target_count[127:96],
   // target_found[128], table_full[129], sample_dropped[130], zeros[135:131]
   output logic [rds_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import rds_pkg::*;
   localparam logic [RTT_W-1:0] DMAX = RTT_W'((32'd1 << DELAY_BITS) - 1);
   localparam int MDV_W = SUM_W + FRAC_W;
   localparam int VDV_W = SQS_W + FRAC_W;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_DST  = 3'd3;
   localparam logic [2:0] S_DWT  = 3'd4;
   localparam logic [2:0] S_MSQ  = 3'd5;
   localparam logic [2:0] S_VAR  = 3'd6;

   logic [2:0]          state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SQS_W-1:0]    sqs_ff;
   logic [RTT_W-1:0]    dly_ff;
   logic                rec_ff;
   logic                drop_ff;
   logic [2*RTT_W-1:0]  sq_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic [SQS_W-1:0]    ex2_ff;
   logic [2*MEAN_W-1:0] msq_ff;
   logic                rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [RTT_W-1:0]    rtt_in;
   logic                accept;
   logic                is_sample;
   logic                out_free;
   logic                div_start;
   logic                mdv_busy, vdv_busy, tbl_busy;
   logic [MDV_W-1:0]    mdv_q;
   logic [VDV_W-1:0]    vdv_q;
   tbl_res_type         tbl_res;
   logic [VAR_W-1:0]    m2;
   logic [VAR_W-1:0]    var_val;
   logic [CNT_W-1:0]    tot_o;
   logic [MEAN_W-1:0]   mean_o;
   logic [VAR_W-1:0]    var_o;
   logic                found_o, full_o, drop_o;

   assign rtt_in    = (req_tdata[RTT_W-1:0] > DMAX) ? DMAX : req_tdata[RTT_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign accept    = req_tvalid && req_tready;
   assign is_sample = !req_tuser;
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign div_start = (state_ff == S_DST);
   assign m2        = msq_ff[2*MEAN_W-1:FRAC_W];
   assign var_val   = (ex2_ff > {{(SQS_W-VAR_W){1'b0}}, m2}) ?
                      VAR_W'(ex2_ff - {{(SQS_W-VAR_W){1'b0}}, m2}) : '0;

   rds_div #(.DVD_W(MDV_W)) u_mean_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({sum_ff, {FRAC_W{1'b0}}}), .divisor(count_ff),
      .busy(mdv_busy), .quotient(mdv_q)
   );

   rds_div #(.DVD_W(VDV_W)) u_msq_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend({sqs_ff, {FRAC_W{1'b0}}}), .divisor(count_ff),
      .busy(vdv_busy), .quotient(vdv_q)
   );

   rds_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .reset(reset), .start(accept),
      .insert(is_sample && count_ff != '1),
      .key(req_tdata[RTT_W +: KEY_W]),
      .busy(tbl_busy), .result(tbl_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         sum_ff     <= '0;
         sqs_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  dly_ff   <= rtt_in;
                  rec_ff   <= is_sample && count_ff != '1;
                  drop_ff  <= is_sample && count_ff == '1;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sq_ff    <= dly_ff * dly_ff;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (rec_ff) begin
                  count_ff <= count_ff + 1'b1;
                  sum_ff   <= sum_ff + SUM_W'(dly_ff);
                  sqs_ff   <= sqs_ff + SQS_W'(sq_ff);
               end
               state_ff <= S_DST;
            end
            S_DST: begin
               state_ff <= S_DWT;
            end
            S_DWT: begin
               if (!mdv_busy && !vdv_busy && !tbl_busy) begin
                  mean_ff  <= (count_ff == '0) ? '0 : mdv_q[MEAN_W-1:0];
                  ex2_ff   <= (count_ff == '0) ? '0 : vdv_q[SQS_W-1:0];
                  state_ff <= S_MSQ;
               end
            end
            S_MSQ: begin
               msq_ff   <= mean_ff * mean_ff;
               state_ff <= S_VAR;
            end
            S_VAR: begin
               if (out_free) begin
                  rsp_vld_ff  <= 1'b1;
                  rsp_data_ff <= {5'b0, drop_ff, tbl_res.full && rec_ff,
                                  tbl_res.found, tbl_res.hits, var_val,
                                  mean_ff, count_ff};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign tot_o   = rsp_data_ff[CNT_W-1:0];
   assign mean_o  = rsp_data_ff[CNT_W +: MEAN_W];
   assign var_o   = rsp_data_ff[CNT_W+MEAN_W +: VAR_W];
   assign found_o = rsp_data_ff[128];
   assign full_o  = rsp_data_ff[129];
   assign drop_o  = rsp_data_ff[130];

`ifndef SYNTHESIS
   a_drop_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && drop_o |-> tot_o == '1)
      else $error("dropped sample without saturated count");
   a_full_found: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(full_o && found_o))
      else $error("table full and target found together");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(full_o && drop_o))
      else $error("dropped sample reported table full");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && tot_o == '0 |-> mean_o == '0 && var_o == '0)
      else $error("nonzero statistics with no samples");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mdv_busy && !vdv_busy)
      else $error("divider busy while block idle");
`endif
endmodule
`default_nettype wire
